// ----- design/lpl_pkg.sv -----
// Shared types and constants for the look-ahead peak limiter.
package lpl_pkg;
  localparam int LookaheadMax = 512;
  localparam int PosBits = $clog2(LookaheadMax);
  localparam int SampleBits = 24;
  localparam logic [23:0] Unity = 24'd8388608;

  typedef enum logic [1:0] {
    REG_CEILING = 2'd0,
    REG_ATTACK  = 2'd1,
    REG_RELEASE = 2'd2,
    REG_LENGTH  = 2'd3
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_READ, ST_PEAK, ST_SCAN, ST_SCAN_END,
    ST_DIV, ST_GAIN, ST_MUL, ST_SCALE, ST_OUT
  } state_e;

  // Status from the divider to the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;
endpackage

// ----- design/lookahead_peak_limiter.sv -----
// Top level of the stereo look-ahead peak limiter.
// Usage: one stereo pair enters per transaction on the s_axis group
// (tdata = left_in[23:0], right_in[47:24]). One result leaves per input
// on the m_axis group (tdata = left_out, right_out, gain_level, low bits
// first). The pair returned is the one written lookahead_len samples
// earlier, scaled by the smoothed gain.
// Configuration is a plain write port: cfg_we_i, cfg_idx_i, cfg_data_i;
// index 0 ceiling, 1 attack, 2 release, 3 look-ahead length.
// Processing: an accepted pair passes through the states READ, PEAK, DIV,
// GAIN, MUL, SCALE and OUT; in DIV the serial divider runs only when the
// window peak is above the ceiling. When the evicted peak forces a rescan,
// the peak ring is walked one entry a cycle in SCAN, and SCAN_END then
// takes the new peak before DIV. A bypass item (ceiling 0) shows its result
// in the cycle after acceptance. One item is in work at a time; the next
// input can be taken at the earliest in the cycle after the result leaves.
// Reset, and any write to the length register, starts a clearing pass
// through all 512 entries of both ring memories; no input is accepted then.
// When the receiver stalls, the result waits in the output register and
// the next input is not taken until it leaves.
module lookahead_peak_limiter import lpl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // left_in[23:0], right_in[47:24]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // left_out, right_out, gain_level
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [23:0] cfg_data_i
);
  // Ring memories: delays packed as one word, peaks separately.
  logic [47:0] dly_mem [LookaheadMax];
  logic [23:0] pk_mem  [LookaheadMax];
  logic [47:0] dly_rd_q;
  logic [23:0] pk_rd_q;
  logic        mem_we;
  logic [PosBits-1:0] waddr, raddr;
  logic [47:0] dly_wd;
  logic [23:0] pk_wd;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      dly_mem[waddr] <= dly_wd;
      pk_mem[waddr]  <= pk_wd;
    end
    dly_rd_q <= dly_mem[raddr];
    pk_rd_q  <= pk_mem[raddr];
  end

  logic [23:0] ceil_q, att_q, rel_q;
  logic [9:0]  len_q;
  state_e      st_q, st_d;
  logic [PosBits-1:0] pos_q, pos_d, scan_q, scan_d;
  logic [PosBits:0]   clr_q, clr_d;
  logic [23:0] wmax_q, wmax_d, gain_q, gain_d, smax_q, smax_d;
  logic [47:0] in_q, in_d;
  logic [23:0] pk_q, pk_d, tgt_q, tgt_d;
  logic [71:0] out_q, out_d;
  logic        ovld_q, ovld_d;
  logic        clr_req;
  logic [9:0]  len_eff;
  logic        div_start;
  logic [23:0] div_quo;
  div_stat_t   div_st;
  logic signed [48:0] prod_l_q, prod_r_q, prod_l_d, prod_r_d;
  logic [48:0] step_prod;
  logic signed [25:0] diff;
  logic [24:0] adiff;
  logic [23:0] coeff;
  logic [23:0] mag_l, mag_r, pk_new;
  logic [34:0] old_x, max_x;

  lpl_div u_div (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(div_start),
    .num_i(ceil_q), .den_i(wmax_q), .quo_o(div_quo), .stat_o(div_st)
  );

  assign clr_req = cfg_we_i && (reg_idx_e'(cfg_idx_i) == REG_LENGTH);
  assign len_eff = (len_q == 10'd0) ? 10'd1 :
                   (len_q > 10'(LookaheadMax)) ? 10'(LookaheadMax) : len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ceil_q <= 24'd1012981; att_q <= 24'd684694; rel_q <= 24'd4369;
      len_q <= 10'd96;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_CEILING: ceil_q <= cfg_data_i;
        REG_ATTACK:  att_q  <= cfg_data_i;
        REG_RELEASE: rel_q  <= cfg_data_i;
        REG_LENGTH:  len_q  <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  assign mag_l = in_q[23] ? 24'(-in_q[23:0]) : in_q[23:0];
  assign mag_r = in_q[47] ? 24'(-in_q[47:24]) : in_q[47:24];
  assign pk_new = (mag_r > mag_l) ? mag_r : mag_l;
  assign old_x = 35'(pk_rd_q) * 35'd1000;
  assign max_x = 35'(wmax_q) * 35'd999;
  assign coeff = (tgt_q < gain_q) ? att_q : rel_q;
  assign diff = $signed({2'b00, tgt_q}) - $signed({2'b00, gain_q});
  assign adiff = diff[25] ? 25'(-diff) : diff[24:0];
  assign step_prod = 49'(adiff) * 49'(coeff);

  always_comb begin
    st_d = st_q; pos_d = pos_q; scan_d = scan_q; clr_d = clr_q;
    wmax_d = wmax_q; gain_d = gain_q; smax_d = smax_q; in_d = in_q;
    pk_d = pk_q; tgt_d = tgt_q; out_d = out_q; ovld_d = ovld_q;
    prod_l_d = prod_l_q; prod_r_d = prod_r_q;
    mem_we = 1'b0; waddr = pos_q; raddr = pos_q;
    dly_wd = in_q; pk_wd = pk_q; div_start = 1'b0;
    s_axis_tready = 1'b0;
    if (ovld_q && m_axis_tready) ovld_d = 1'b0;
    case (st_q)
      ST_CLEAR: begin
        mem_we = 1'b1; waddr = clr_q[PosBits-1:0]; dly_wd = '0; pk_wd = '0;
        clr_d = clr_q + 1'b1;
        if (clr_q == (PosBits+1)'(LookaheadMax - 1)) st_d = ST_IDLE;
      end
      ST_IDLE: begin
        s_axis_tready = !ovld_q;
        if (s_axis_tvalid && !ovld_q) begin
          in_d = s_axis_tdata;
          if (ceil_q == 24'd0) begin
            out_d = {gain_q, s_axis_tdata}; ovld_d = 1'b1;
          end else begin
            if (10'(pos_q) >= len_eff) pos_d = '0;
            st_d = ST_READ;
          end
        end
      end
      ST_READ: st_d = ST_PEAK;  // read address pos_q issued here
      ST_PEAK: begin
        pk_d = pk_new;
        mem_we = 1'b1; pk_wd = pk_new;
        if (pk_new >= wmax_q) begin
          wmax_d = pk_new; st_d = ST_DIV;
        end else if (old_x >= max_x) begin
          scan_d = '0; smax_d = '0; st_d = ST_SCAN;
        end else st_d = ST_DIV;
        // Delayed pair read out now feeds the output stage later.
        in_d = dly_rd_q;
      end
      ST_SCAN: begin
        raddr = scan_q;
        if (scan_q != '0 && pk_rd_q > smax_q) smax_d = pk_rd_q;
        scan_d = scan_q + 1'b1;
        if (10'(scan_q) == len_eff - 10'd1) st_d = ST_SCAN_END;
      end
      ST_SCAN_END: begin
        wmax_d = (pk_rd_q > smax_q) ? pk_rd_q : smax_q;
        st_d = ST_DIV;
      end
      ST_DIV: begin
        if (wmax_q > ceil_q) begin
          if (!div_st.busy && !div_st.done && tgt_q != 24'hFFFFFF) begin
            div_start = 1'b1; tgt_d = 24'hFFFFFF;
          end else if (div_st.done) begin
            tgt_d = div_quo; st_d = ST_GAIN;
          end
        end else begin
          tgt_d = Unity; st_d = ST_GAIN;
        end
      end
      ST_GAIN: begin
        if (!diff[25]) gain_d = gain_q + step_prod[47:24];
        else gain_d = gain_q - 24'((step_prod + 49'hFFFFFF) >> 24);
        st_d = ST_MUL;
      end
      ST_MUL: begin
        prod_l_d = 49'($signed(in_q[23:0])) * $signed({1'b0, gain_q});
        prod_r_d = 49'($signed(in_q[47:24])) * $signed({1'b0, gain_q});
        st_d = ST_SCALE;
      end
      ST_SCALE: begin
        prod_l_d = prod_l_q + 49'sd4194304;
        prod_r_d = prod_r_q + 49'sd4194304;
        st_d = ST_OUT;
      end
      ST_OUT: begin
        out_d = {gain_q, prod_r_q[46:23], prod_l_q[46:23]};
        ovld_d = 1'b1;
        pos_d = (10'(pos_q) + 10'd1 >= len_eff) ? '0 : pos_q + 1'b1;
        st_d = ST_IDLE;
      end
      default: st_d = ST_IDLE;
    endcase
    if (clr_req) begin
      st_d = ST_CLEAR; clr_d = '0; pos_d = '0; wmax_d = '0; gain_d = Unity;
    end
  end

  // Writing the delay pair in ST_PEAK reuses dly_wd = in_q before in_q
  // is replaced by the read data (in_d takes effect next cycle).

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_CLEAR; clr_q <= '0; pos_q <= '0; wmax_q <= '0;
      gain_q <= Unity; ovld_q <= 1'b0; scan_q <= '0; tgt_q <= '0;
    end else begin
      st_q <= st_d; clr_q <= clr_d; pos_q <= pos_d; wmax_q <= wmax_d;
      gain_q <= gain_d; ovld_q <= ovld_d; scan_q <= scan_d;
      tgt_q <= (st_q == ST_IDLE) ? 24'd0 : tgt_d;
    end
  end
  always_ff @(posedge clk_i) begin
    smax_q <= smax_d; in_q <= in_d; pk_q <= pk_d; out_q <= out_d;
    prod_l_q <= prod_l_d; prod_r_q <= prod_r_d;
  end

  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> (st_q == ST_IDLE && !ovld_q))
    else $error("input taken while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovld_q && !m_axis_tready) |=> $stable(out_q))
    else $error("pending result changed");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == ST_OUT |-> !ovld_q)
    else $error("result overwritten");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    gain_q <= Unity)
    else $error("gain above unity");
endmodule

// ----- design/lpl_div.sv -----
// Restoring divider, one quotient bit per cycle: quotient of ceiling * 2^23 / peak.
module lpl_div import lpl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [23:0] num_i,
  input  logic [23:0] den_i,
  output logic [23:0] quo_o,
  output div_stat_t   stat_o
);
  logic [46:0] num_q, num_d;
  logic [24:0] rem_q, rem_d;
  logic [23:0] den_q, den_d;
  logic [46:0] quo_q, quo_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [24:0] trial;

  always_comb begin
    num_d = num_q; rem_d = rem_q; den_d = den_q; quo_d = quo_q;
    cnt_d = cnt_q; busy_d = busy_q; done_d = 1'b0;
    trial = {rem_q[23:0], num_q[46]};
    if (start_i) begin
      num_d = {num_i, 23'd0}; rem_d = '0; den_d = den_i; quo_d = '0;
      cnt_d = 6'd47; busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[45:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q}; quo_d = {quo_q[45:0], 1'b1};
      end else begin
        rem_d = trial; quo_d = {quo_q[45:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end
  always_ff @(posedge clk_i) begin
    num_q <= num_d; rem_q <= rem_d; den_q <= den_d; quo_q <= quo_d;
  end

  // Quotient stays below 2^24 whenever peak exceeds ceiling.
  assign quo_o = quo_q[23:0];
  assign stat_o = '{busy: busy_q, done: done_q};

  assert property (@(posedge clk_i) disable iff (!rst_ni) done_q |-> !busy_q)
    else $error("divider done while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && cnt_q == 6'd1 && !start_i) |=> done_q)
    else $error("divider missed done");
  assert property (@(posedge clk_i) disable iff (!rst_ni) start_i |=> busy_q)
    else $error("divider did not start");
endmodule
